>>> rtl/led_bwp_pkg.sv
// ----------------------------------------------------------------------------
// LED bit-plane word packer package
// Shared word types, segment constants and packing functions.
// ----------------------------------------------------------------------------
package led_bwp_pkg;

	localparam int SEG_LEN = 20;
	localparam logic [31:0] END_OF_ROW = 32'h8000_0000;
	localparam logic [4:0] SEG_LAST = 5'(SEG_LEN - 1);
	localparam logic [4:0] MOD_ROW_A = 5'd7;
	localparam logic [4:0] MOD_ROW_B = 5'd14;

	typedef struct packed {
		logic [7:0] pixel;
		logic       frame_start;
	} in_t;

	typedef struct packed {
		logic [1:0]  plane;
		logic [5:0]  out_row;
		logic [1:0]  out_slot;
		logic [31:0] word;
		logic        last;
		logic        frame_done;
	} out_t;

	// Spread 20 segment bits over the three byte lanes of a shift word.
	function automatic logic [31:0] pack_segment(input logic [SEG_LEN-1:0] bits);
		logic [31:0] w;
		w = '0;
		w[6:1]   = bits[5:0];
		w[14:8]  = bits[12:6];
		w[22:16] = bits[19:13];
		return w;
	endfunction

	// Row-select word: row-zero flag in bit 0, extra pulse count above it.
	function automatic logic [31:0] row_select(input logic [4:0] in_mod,
		input logic mod_nz, input logic row0);
		logic       first;
		logic       bonus;
		logic [1:0] extra;
		first = (in_mod == 5'd0);
		bonus = (in_mod == MOD_ROW_A) || (in_mod == MOD_ROW_B) || (first && mod_nz);
		extra = {1'b0, first} + {1'b0, bonus};
		return {29'd0, extra, row0};
	endfunction

endpackage

>>> rtl/led_bitplane_word_packer.sv
// ----------------------------------------------------------------------------
// LED bit-plane word packer
// Packs 20-pixel module segments into per-plane shift words and appends
// per-plane row-select words at the end of every output row.
// ----------------------------------------------------------------------------
// Throughput: one pixel word per cycle; the word emitter sends one result per
//   cycle while the receiver does not stall, PLANES words per segment plus
//   PLANES row-select words at row end. A finished segment goes to the burst
//   registers, then to the output register when free; input stalls only when
//   a segment completes while the previous burst is still draining.
// Reset: arst_n clears position counters and handshake state; plane bits
//   and payload registers are not reset.
module led_bitplane_word_packer #(
	parameter int PLANES   = 4,
	parameter int ROW_MODS = 2,
	parameter int COL_MODS = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  led_bwp_pkg::in_t   in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output led_bwp_pkg::out_t  out_data
);
	import led_bwp_pkg::*;

	localparam int FRAME_ROWS = ROW_MODS * SEG_LEN;
	localparam int ROW_W  = $clog2(FRAME_ROWS);
	localparam int SLOT_W = (COL_MODS > 1) ? $clog2(COL_MODS) : 1;
	localparam int RMOD_W = (ROW_MODS > 1) ? $clog2(ROW_MODS) : 1;
	localparam int PL_W   = (PLANES > 1) ? $clog2(PLANES) : 1;

	// Position of the next buffer pixel.
	logic [4:0]        seg_idx_q;
	logic [SLOT_W-1:0] slot_q;
	logic [ROW_W-1:0]  row_q;
	logic [4:0]        row_in_mod_q;
	logic [RMOD_W-1:0] row_mod_q;

	logic [SEG_LEN-1:0] plane_bits_q [PLANES];

	// Captured burst waiting for the emitter.
	logic              burst_valid_q;
	logic [31:0]       shift_word_q [PLANES];
	logic [31:0]       sel_word_q;
	logic [5:0]        burst_row_q;
	logic [1:0]        burst_slot_q;
	logic              burst_eor_q;
	logic              burst_final_q;
	logic [PL_W-1:0]   pl_q;
	logic              phase_q;

	logic              out_valid_q;
	out_t              out_q;

	// Effective position after a frame restart.
	logic [4:0]        seg_eff;
	logic [SLOT_W-1:0] slot_eff;
	logic [ROW_W-1:0]  row_eff;
	logic [4:0]        row_in_mod_eff;
	logic [RMOD_W-1:0] row_mod_eff;

	logic              accept;
	logic              seg_done;
	logic              capture;
	logic              row_end;
	logic              frame_end;
	logic [ROW_W-1:0]  orow;
	logic [4:0]        o_in_mod;
	logic [RMOD_W-1:0] o_mod;
	logic [SEG_LEN-1:0] bits_new [PLANES];

	logic              emit;
	logic              plane_wrap;
	logic              entry_last;

	assign in_ready = !burst_valid_q || (seg_idx_q != SEG_LAST);
	assign accept   = in_valid && in_ready;

	always_comb begin
		if (in_data.frame_start) begin
			seg_eff        = '0;
			slot_eff       = '0;
			row_eff        = '0;
			row_in_mod_eff = '0;
			row_mod_eff    = '0;
		end else begin
			seg_eff        = seg_idx_q;
			slot_eff       = slot_q;
			row_eff        = row_q;
			row_in_mod_eff = row_in_mod_q;
			row_mod_eff    = row_mod_q;
		end
	end

	assign seg_done  = (seg_eff == SEG_LAST);
	assign row_end   = seg_done && (slot_eff == SLOT_W'(COL_MODS - 1));
	assign frame_end = row_end && (row_eff == ROW_W'(FRAME_ROWS - 1));
	assign capture   = accept && seg_done;

	// Flip rows: buffer row r drives output row FRAME_ROWS-1-r.
	assign orow     = ROW_W'(FRAME_ROWS - 1) - row_eff;
	assign o_in_mod = SEG_LAST - row_in_mod_eff;
	assign o_mod    = RMOD_W'(ROW_MODS - 1) - row_mod_eff;

	// Drop the current pixel's plane bits into their segment slots.
	always_comb begin
		for (int b = 0; b < PLANES; b++) begin
			for (int x = 0; x < SEG_LEN; x++) begin
				if (5'(x) == seg_eff) begin
					bits_new[b][x] = in_data.pixel[b + 8 - PLANES];
				end else begin
					bits_new[b][x] = plane_bits_q[b][x];
				end
			end
		end
	end

	// Advance the buffer position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_idx_q    <= '0;
			slot_q       <= '0;
			row_q        <= '0;
			row_in_mod_q <= '0;
			row_mod_q    <= '0;
		end else if (accept) begin
			if (!seg_done) begin
				seg_idx_q    <= seg_eff + 5'd1;
				slot_q       <= slot_eff;
				row_q        <= row_eff;
				row_in_mod_q <= row_in_mod_eff;
				row_mod_q    <= row_mod_eff;
			end else if (!row_end) begin
				seg_idx_q    <= '0;
				slot_q       <= slot_eff + SLOT_W'(1);
				row_q        <= row_eff;
				row_in_mod_q <= row_in_mod_eff;
				row_mod_q    <= row_mod_eff;
			end else if (frame_end) begin
				seg_idx_q    <= '0;
				slot_q       <= '0;
				row_q        <= '0;
				row_in_mod_q <= '0;
				row_mod_q    <= '0;
			end else begin
				seg_idx_q <= '0;
				slot_q    <= '0;
				row_q     <= row_eff + ROW_W'(1);
				if (row_in_mod_eff == SEG_LAST) begin
					row_in_mod_q <= '0;
					row_mod_q    <= row_mod_eff + RMOD_W'(1);
				end else begin
					row_in_mod_q <= row_in_mod_eff + 5'd1;
					row_mod_q    <= row_mod_eff;
				end
			end
		end
	end

	// Hold the segment bits and latch a finished burst.
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int b = 0; b < PLANES; b++) begin
				plane_bits_q[b] <= bits_new[b];
			end
		end
		if (capture) begin
			for (int b = 0; b < PLANES; b++) begin
				shift_word_q[b] <= pack_segment(bits_new[b]) |
					(row_end ? END_OF_ROW : 32'd0);
			end
			sel_word_q    <= row_select(o_in_mod, o_mod != '0, orow == '0);
			burst_row_q   <= 6'(orow);
			burst_slot_q  <= 2'(slot_eff);
			burst_eor_q   <= row_end;
			burst_final_q <= frame_end;
		end
	end

	// Emitter: walk shift words, then row-select words on a row end.
	assign emit       = burst_valid_q && (!out_valid_q || out_ready);
	assign plane_wrap = (pl_q == PL_W'(PLANES - 1));
	assign entry_last = plane_wrap && (phase_q || !burst_eor_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_valid_q <= 1'b0;
			pl_q          <= '0;
			phase_q       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (capture) begin
				burst_valid_q <= 1'b1;
				pl_q          <= '0;
				phase_q       <= 1'b0;
			end else if (emit) begin
				if (plane_wrap) begin
					pl_q <= '0;
					if (entry_last) begin
						burst_valid_q <= 1'b0;
						phase_q       <= 1'b0;
					end else begin
						phase_q <= 1'b1;
					end
				end else begin
					pl_q <= pl_q + PL_W'(1);
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.plane      <= 2'(pl_q);
			out_q.out_row    <= burst_row_q;
			out_q.out_slot   <= phase_q ? 2'(COL_MODS) : burst_slot_q;
			out_q.word       <= phase_q ? sel_word_q : shift_word_q[pl_q];
			out_q.last       <= entry_last;
			out_q.frame_done <= entry_last && burst_final_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_done |-> out_data.last)
		else $error("frame_done without last");

	a_select_needs_eor: assert property (@(posedge clk) disable iff (!arst_n)
		burst_valid_q && phase_q |-> burst_eor_q)
		else $error("row-select phase outside a row end");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		capture |-> !burst_valid_q)
		else $error("burst captured while previous burst draining");

	a_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		seg_idx_q <= SEG_LAST)
		else $error("segment index out of range");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		emit && entry_last && !capture |=> !burst_valid_q)
		else $error("burst still valid after final entry");
`endif

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// LED bit-plane word packer testbench
// Streams pixels through the packer under several idle and stall mixes. A
// word-level predictor builds the expected shift and row-select words from
// each accepted pixel, and the monitor checks every delivered word against it.
// ----------------------------------------------------------------------------
module tb;

	import led_bwp_pkg::*;

	localparam int PLANES       = 4;
	localparam int ROW_MODS     = 2;
	localparam int COL_MODS     = 2;
	localparam int FRAME_ROWS   = ROW_MODS * SEG_LEN;
	localparam int FRAME_COLS   = COL_MODS * SEG_LEN;
	localparam int SETTLE_CYCLES = 20;
	localparam int RUN_LIMIT     = 2000000;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_ready;
	in_t  in_data   = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	// Pixels waiting for the driver, and words the packer still owes us.
	in_t  pending_pixels [$];
	out_t expected_words [$];

	// Predictor copy of the packer state.
	logic [SEG_LEN-1:0] seg_bits [PLANES];
	int unsigned        col_pos = 0;
	int unsigned        row_pos = 0;

	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int mismatches     = 0;

	led_bitplane_word_packer #(
		.PLANES  (PLANES),
		.ROW_MODS(ROW_MODS),
		.COL_MODS(COL_MODS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #2 clk = ~clk;

	// Spread segment bits into the three byte lanes: 0-5 at 1-6, 6-12 at 8-14,
	// 13-19 at 16-22.
	function automatic logic [31:0] lane_spread(input logic [SEG_LEN-1:0] bits);
		logic [31:0] w;
		int          pos;
		w = '0;
		for (int x = 0; x < SEG_LEN; x++) begin
			pos = (x < 6) ? x + 1 : (x < 13) ? x + 2 : x + 3;
			w[pos] = bits[x];
		end
		return w;
	endfunction

	// Row-select word: bit 0 flags output row 0, the extra pulse count sits above.
	// First row of each module gets one pulse, rows 7 and 14 get one, and the
	// first row of every module but the lowest gets a second one.
	function automatic logic [31:0] row_strobe_word(input int unsigned y);
		int unsigned in_mod;
		int unsigned extra;
		in_mod = y % SEG_LEN;
		extra  = (in_mod == 0) ? 1 : 0;
		if (in_mod == 7 || in_mod == 14 || (in_mod == 0 && y >= SEG_LEN))
			extra++;
		return 32'((y == 0) ? 1 : 0) | 32'(extra << 1);
	endfunction

	// Fold one accepted pixel into the predictor and queue the words it causes.
	task automatic accept_pixel(input in_t px);
		out_t        burst [2*PLANES];
		int          n;
		int unsigned seg;
		int unsigned slot;
		int unsigned orow;
		bit          frame_end;
		n = 0;
		if (px.frame_start) begin
			col_pos = 0;
			row_pos = 0;
		end
		seg = col_pos % SEG_LEN;
		for (int b = 0; b < PLANES; b++)
			seg_bits[b][seg] = px.pixel[b + 8 - PLANES];
		frame_end = (row_pos == FRAME_ROWS - 1) && (col_pos == FRAME_COLS - 1);
		if (seg == SEG_LEN - 1) begin
			slot = col_pos / SEG_LEN;
			orow = FRAME_ROWS - 1 - row_pos;
			for (int b = 0; b < PLANES; b++) begin
				burst[n].plane      = 2'(b);
				burst[n].out_row    = 6'(orow);
				burst[n].out_slot   = 2'(slot);
				burst[n].word       = lane_spread(seg_bits[b]) |
					((slot == COL_MODS - 1) ? END_OF_ROW : 32'd0);
				burst[n].last       = 1'b0;
				burst[n].frame_done = 1'b0;
				n++;
			end
			// Append row-select words once the row's last module is out.
			if (slot == COL_MODS - 1) begin
				for (int b = 0; b < PLANES; b++) begin
					burst[n].plane      = 2'(b);
					burst[n].out_row    = 6'(orow);
					burst[n].out_slot   = 2'(COL_MODS);
					burst[n].word       = row_strobe_word(orow);
					burst[n].last       = 1'b0;
					burst[n].frame_done = 1'b0;
					n++;
				end
			end
			burst[n-1].last       = 1'b1;
			burst[n-1].frame_done = frame_end;
			for (int k = 0; k < n; k++)
				expected_words.push_back(burst[k]);
		end
		// Advance the position; wrap to the frame start after the final pixel.
		col_pos++;
		if (col_pos >= FRAME_COLS) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= FRAME_ROWS)
				row_pos = 0;
		end
	endtask

	task automatic check_word(input out_t got);
		out_t want;
		if (expected_words.size() == 0) begin
			$display("%0t: unexpected word plane=%0d row=%0d slot=%0d word=%h last=%b done=%b",
				$time, got.plane, got.out_row, got.out_slot, got.word, got.last,
				got.frame_done);
			mismatches++;
		end else begin
			want = expected_words.pop_front();
			if (got.plane !== want.plane || got.out_row !== want.out_row ||
				got.out_slot !== want.out_slot || got.word !== want.word ||
				got.last !== want.last || got.frame_done !== want.frame_done) begin
				$display("%0t: expected plane=%0d row=%0d slot=%0d word=%h last=%b done=%b",
					$time, want.plane, want.out_row, want.out_slot, want.word,
					want.last, want.frame_done);
				$display("%0t: actual   plane=%0d row=%0d slot=%0d word=%h last=%b done=%b",
					$time, got.plane, got.out_row, got.out_slot, got.word, got.last,
					got.frame_done);
				mismatches++;
			end
		end
	endtask

	// Driver: offer the next pending pixel once the previous one is taken, or
	// go idle at the current rate. Valid holds with its payload until accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
				in_valid <= 1'b1;
				in_data  <= pending_pixels.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall at random at the current rate.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	// Monitor: predict on every accepted pixel, check every delivered word.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				accept_pixel(in_data);
			if (out_valid && out_ready)
				check_word(out_data);
		end
	end

	task automatic queue_pixel(input logic [7:0] px, input logic restart);
		in_t item;
		item.pixel       = px;
		item.frame_start = restart;
		pending_pixels.push_back(item);
	endtask

	// Mostly uniform pixels, with the all-off and all-on values thrown in often.
	function automatic logic [7:0] rand_pixel();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Random pixels; a few carry frame_start and break the current segment.
	task automatic queue_random(input int count, input int restart_pct);
		for (int i = 0; i < count; i++)
			queue_pixel(rand_pixel(), $urandom_range(0, 99) < restart_pct);
	endtask

	// Hold the sender until every queued pixel is taken and every word is back.
	task automatic drain();
		while (pending_pixels.size() != 0 || in_valid || expected_words.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// No idling on either side.
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		queue_pixel(8'hFF, 1'b1);
		queue_pixel(8'h00, 1'b0);
		queue_pixel(8'h80, 1'b0);
		queue_pixel(8'h7F, 1'b0);
		queue_pixel(8'h55, 1'b0);
		// Restart mid-segment: the five pixels above are dropped.
		queue_pixel(8'hF0, 1'b1);
		for (int i = 1; i < SEG_LEN; i++)
			queue_pixel(8'(i * 37 + 11), 1'b0);
		queue_random(60, 2);
		drain();

		// Sender idle: one full row so its last module carries the row-select
		// words, then one segment of the next row.
		src_idle_pct = 57;
		queue_pixel(rand_pixel(), 1'b1);
		repeat (FRAME_COLS + SEG_LEN - 1)
			queue_pixel(rand_pixel(), 1'b0);
		drain();

		// Receiver stalling.
		src_idle_pct   = 0;
		sink_stall_pct = 57;
		queue_random(45, 3);
		drain();

		// Both sides idle.
		src_idle_pct   = 22;
		sink_stall_pct = 22;
		queue_random(40, 3);
		drain();

		// Give any stray word time to show up.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#RUN_LIMIT;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
